### src/mm4_pkg.sv
`timescale 1ns / 1ps
package mm4_pkg;

	localparam int ELEM_W          = 32;
	localparam int ROW_W           = 2;
	localparam int NUM_ELEM_FIELDS = 4;
	localparam int PROD_W          = 2 * ELEM_W;

	localparam int DIM_DEFAULT       = 4;
	localparam int FRAC_BITS_DEFAULT = 16;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_MULT = 1'b1;

	localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic             kind;
		logic [ROW_W-1:0] row;
	} ctl_t;

endpackage

### src/mm4_cell.sv
`timescale 1ns / 1ps
// One step of the dot-product chain. The cell holds row IDX of the right-hand
// matrix, multiplies it by element IDX of the passing row and adds the
// products onto the running column sums.
module mm4_cell #(
	parameter int DIM   = mm4_pkg::DIM_DEFAULT,
	parameter int NCOL  = 4,
	parameter int ACC_W = 66,
	parameter int IDX   = 0
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      up_valid,
	input  mm4_pkg::ctl_t                             up_ctl,
	input  logic [DIM-1:0][mm4_pkg::ELEM_W-1:0]       up_a,
	input  logic [NCOL-1:0][ACC_W-1:0]                up_psum,
	output logic                                      up_ready,
	output logic                                      dn_valid,
	output mm4_pkg::ctl_t                             dn_ctl,
	output logic [DIM-1:0][mm4_pkg::ELEM_W-1:0]       dn_a,
	output logic [NCOL-1:0][ACC_W-1:0]                dn_psum,
	input  logic                                      dn_ready
);

	logic [mm4_pkg::ELEM_W-1:0]                b_q [NCOL];

	logic                                      v_s1;
	mm4_pkg::ctl_t                             ctl_s1;
	logic [DIM-1:0][mm4_pkg::ELEM_W-1:0]       a_s1;
	logic signed [ACC_W-1:0]                   psum_s1 [NCOL];
	logic signed [mm4_pkg::PROD_W-1:0]         prod_s1 [NCOL];

	logic                                      v_s2;
	mm4_pkg::ctl_t                             ctl_s2;
	logic [DIM-1:0][mm4_pkg::ELEM_W-1:0]       a_s2;
	logic signed [ACC_W-1:0]                   psum_s2 [NCOL];

	logic rdy_s1;
	logic rdy_s2;
	logic take_s1;
	logic row_hit;

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;
	assign take_s1  = up_valid && rdy_s1;
	assign row_hit  = (int'(up_ctl.row) == IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// A load updates this row before any later item reaches the multiplier.
	always_ff @(posedge clk) begin
		if (take_s1 && up_ctl.kind == mm4_pkg::KIND_LOAD && row_hit) begin
			for (int c = 0; c < NCOL; c++) begin
				b_q[c] <= up_a[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			ctl_s1 <= up_ctl;
			a_s1   <= up_a;
			for (int c = 0; c < NCOL; c++) begin
				psum_s1[c] <= $signed(up_psum[c]);
				prod_s1[c] <= $signed(up_a[IDX]) * $signed(b_q[c]);
			end
		end
		if (rdy_s2 && v_s1) begin
			ctl_s2 <= ctl_s1;
			a_s2   <= a_s1;
			for (int c = 0; c < NCOL; c++) begin
				psum_s2[c] <= psum_s1[c] + ACC_W'(prod_s1[c]);
			end
		end
	end

	assign dn_valid = v_s2;
	assign dn_ctl   = ctl_s2;
	assign dn_a     = a_s2;

	always_comb begin
		for (int c = 0; c < NCOL; c++) begin
			dn_psum[c] = psum_s2[c];
		end
	end

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !dn_ready |=> v_s2 && $stable(psum_s2[0]))
		else $error("cell %0d lost or changed a stalled sum", IDX);

	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!up_ready |-> v_s1 && v_s2)
		else $error("cell %0d stalled with a free stage", IDX);

endmodule

### src/mm4_out.sv
`timescale 1ns / 1ps
// Rounding, saturation and the result register at the end of the chain.
module mm4_out #(
	parameter int NCOL      = 4,
	parameter int ACC_W     = 66,
	parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                                                       clk,
	input  logic                                                       arst_n,
	input  logic                                                       up_valid,
	input  mm4_pkg::ctl_t                                              up_ctl,
	input  logic [NCOL-1:0][ACC_W-1:0]                                 up_psum,
	output logic                                                       up_ready,
	output logic                                                       valid,
	output logic [mm4_pkg::ROW_W-1:0]                                  row,
	output logic [mm4_pkg::NUM_ELEM_FIELDS-1:0][mm4_pkg::ELEM_W-1:0]   data,
	output logic                                                       sat,
	input  logic                                                       stall
);

	localparam int UP_W = ACC_W - mm4_pkg::ELEM_W + 1;

	logic [mm4_pkg::NUM_ELEM_FIELDS-1:0][mm4_pkg::ELEM_W-1:0] col_d;
	logic [mm4_pkg::NUM_ELEM_FIELDS-1:0]                      clip_d;

	logic                                                     valid_q;
	logic [mm4_pkg::ROW_W-1:0]                                row_q;
	logic [mm4_pkg::NUM_ELEM_FIELDS-1:0][mm4_pkg::ELEM_W-1:0] data_q;
	logic                                                     sat_q;

	for (genvar c = 0; c < mm4_pkg::NUM_ELEM_FIELDS; c++) begin : g_col
		if (c < NCOL) begin : g_live
			logic signed [ACC_W-1:0] shifted;
			logic [UP_W-1:0]         upper;
			logic                    fits;
			assign shifted = $signed(up_psum[c]) >>> FRAC_BITS;
			assign upper   = shifted[ACC_W-1:mm4_pkg::ELEM_W-1];
			assign fits    = (&upper) || !(|upper);
			assign clip_d[c] = !fits;
			assign col_d[c]  = fits ? shifted[mm4_pkg::ELEM_W-1:0] :
				(shifted[ACC_W-1] ? mm4_pkg::SAT_MIN : mm4_pkg::SAT_MAX);
		end else begin : g_none
			assign clip_d[c] = 1'b0;
			assign col_d[c]  = '0;
		end
	end

	assign up_ready = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid && up_ctl.kind == mm4_pkg::KIND_MULT;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			row_q  <= up_ctl.row;
			data_q <= col_d;
			sat_q  <= |clip_d;
		end
	end

	assign valid = valid_q;
	assign row   = row_q;
	assign data  = data_q;
	assign sat   = sat_q;

endmodule

### src/matrix_multiply_4x4_top.sv
`timescale 1ns / 1ps
// Row-at-a-time 4x4 fixed-point matrix product C = A * B, elements in signed
// Q16.16 (FRAC_BITS fraction bits). Items arrive on the item channel
// (item_valid / item_stall). A load item (kind 0) writes row row_index of B
// and returns nothing. A multiply item (kind 1) carries one row of A and
// returns row row_index of C on the result channel (result_valid /
// result_stall), each element rounded to nearest, ties upward, and clipped
// to 32 bits, with saturated set when any element of the row was clipped.
// For a vector transform send a multiply item whose fourth element is 1.0
// and keep the first three outputs.
// Throughput is one item per cycle while the result channel does not
// stall. A multiply result passes through the chain of DIM cells, each a
// multiply stage and an add stage, and then the result register. Rows of
// B must be loaded before they are used; a load takes effect for every
// item accepted after it.
// Reset clears only the pipeline valid bits; the stored B is undefined until
// loaded. When the receiver stalls, the result register holds its item and
// the chain keeps filling its empty stages, so the item channel stalls only
// once every stage holds an item.
module matrix_multiply_4x4_top #(
	parameter int DIM       = mm4_pkg::DIM_DEFAULT,
	parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               kind,
	input  logic [mm4_pkg::ROW_W-1:0]          row_index,
	input  logic signed [mm4_pkg::ELEM_W-1:0]  elem_0,
	input  logic signed [mm4_pkg::ELEM_W-1:0]  elem_1,
	input  logic signed [mm4_pkg::ELEM_W-1:0]  elem_2,
	input  logic signed [mm4_pkg::ELEM_W-1:0]  elem_3,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [mm4_pkg::ROW_W-1:0]          out_row,
	output logic signed [mm4_pkg::ELEM_W-1:0]  out_0,
	output logic signed [mm4_pkg::ELEM_W-1:0]  out_1,
	output logic signed [mm4_pkg::ELEM_W-1:0]  out_2,
	output logic signed [mm4_pkg::ELEM_W-1:0]  out_3,
	output logic                               saturated
);

	// Only the first four columns are ever reported, so only those are built.
	localparam int NCOL  = (DIM < mm4_pkg::NUM_ELEM_FIELDS) ? DIM :
		mm4_pkg::NUM_ELEM_FIELDS;
	// A sum of DIM full-range products, plus the rounding half, fits here.
	localparam int ACC_W = mm4_pkg::PROD_W + $clog2(DIM);
	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

	logic [mm4_pkg::ELEM_W-1:0] elem_arr [mm4_pkg::NUM_ELEM_FIELDS];

	logic                                      ch_valid [DIM+1];
	mm4_pkg::ctl_t                             ch_ctl   [DIM+1];
	logic [DIM-1:0][mm4_pkg::ELEM_W-1:0]       ch_a     [DIM+1];
	logic [NCOL-1:0][ACC_W-1:0]                ch_psum  [DIM+1];
	logic                                      ch_ready [DIM+1];

	logic [mm4_pkg::NUM_ELEM_FIELDS-1:0][mm4_pkg::ELEM_W-1:0] res_data;
	logic row_ok;

	assign elem_arr[0] = elem_0;
	assign elem_arr[1] = elem_1;
	assign elem_arr[2] = elem_2;
	assign elem_arr[3] = elem_3;

	// Rows beyond the matrix (only possible for a small DIM) are accepted
	// and dropped here: a load changes nothing and a multiply returns nothing.
	assign row_ok = (int'(row_index) < DIM);

	assign ch_valid[0]    = item_valid && row_ok;
	assign ch_ctl[0].kind = kind;
	assign ch_ctl[0].row  = row_index;
	assign item_stall     = !ch_ready[0];

	// Elements past the fourth column of a wide matrix enter as zero.
	for (genvar k = 0; k < DIM; k++) begin : g_a
		if (k < mm4_pkg::NUM_ELEM_FIELDS) begin : g_field
			assign ch_a[0][k] = elem_arr[k];
		end else begin : g_zero
			assign ch_a[0][k] = '0;
		end
	end

	// Each column sum starts from half an LSB so the final shift rounds.
	for (genvar c = 0; c < NCOL; c++) begin : g_seed
		assign ch_psum[0][c] = HALF;
	end

	for (genvar k = 0; k < DIM; k++) begin : g_cell
		mm4_cell #(
			.DIM   (DIM),
			.NCOL  (NCOL),
			.ACC_W (ACC_W),
			.IDX   (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (ch_valid[k]),
			.up_ctl   (ch_ctl[k]),
			.up_a     (ch_a[k]),
			.up_psum  (ch_psum[k]),
			.up_ready (ch_ready[k]),
			.dn_valid (ch_valid[k+1]),
			.dn_ctl   (ch_ctl[k+1]),
			.dn_a     (ch_a[k+1]),
			.dn_psum  (ch_psum[k+1]),
			.dn_ready (ch_ready[k+1])
		);
	end

	mm4_out #(
		.NCOL      (NCOL),
		.ACC_W     (ACC_W),
		.FRAC_BITS (FRAC_BITS)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (ch_valid[DIM]),
		.up_ctl   (ch_ctl[DIM]),
		.up_psum  (ch_psum[DIM]),
		.up_ready (ch_ready[DIM]),
		.valid    (result_valid),
		.row      (out_row),
		.data     (res_data),
		.sat      (saturated),
		.stall    (result_stall)
	);

	assign out_0 = res_data[0];
	assign out_1 = res_data[1];
	assign out_2 = res_data[2];
	assign out_3 = res_data[3];

	a_free_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("item channel stalled with an empty result register");

	a_sat_has_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |->
			out_0 == mm4_pkg::SAT_MAX || out_0 == mm4_pkg::SAT_MIN ||
			out_1 == mm4_pkg::SAT_MAX || out_1 == mm4_pkg::SAT_MIN ||
			out_2 == mm4_pkg::SAT_MAX || out_2 == mm4_pkg::SAT_MIN ||
			out_3 == mm4_pkg::SAT_MAX || out_3 == mm4_pkg::SAT_MIN)
		else $error("saturated flag set but no element sits at a bound");

endmodule
